>>> rtl/core/flagged_sign_magnitude_alu_macros.svh
// Assertion macros used by the ALU top module.
`ifndef FLAGGED_SIGN_MAGNITUDE_ALU_MACROS_SVH
`define FLAGGED_SIGN_MAGNITUDE_ALU_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define FSM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define FSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/fsma_pkg.sv
package fsma_pkg;

  localparam int MagW   = 64;
  localparam int Stages = 64;
  localparam int IdxW   = 6;
  localparam int Lat    = Stages + 2;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_MOD = 3'd4,
    MODE_CMP = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ORD_LESS    = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_GREATER = 2'd2,
    ORD_UNORD   = 2'd3
  } order_e;

  typedef struct packed {
    logic [2:0]      mode;
    logic [MagW-1:0] a_magnitude;
    logic            a_positive;
    logic            a_infinite;
    logic            a_notnum;
    logic [MagW-1:0] b_magnitude;
    logic            b_positive;
    logic            b_infinite;
    logic            b_notnum;
  } in_item_t;

  typedef struct packed {
    logic [MagW-1:0] r_magnitude;
    logic            r_positive;
    logic            r_infinite;
    logic            r_notnum;
    logic [1:0]      order;
  } out_item_t;

  // Word that travels down the cell row: one partial result per stage.
  typedef struct packed {
    logic              vld;
    in_item_t          op;
    logic [MagW-1:0]   rem;     // division remainder so far
    logic [MagW-1:0]   quo;     // quotient bits so far
    logic [2*MagW-1:0] prod;    // running product
    logic [2*MagW-1:0] mcand;   // zero-extended multiplicand
  } cell_data_t;

endpackage

>>> rtl/core/flagged_sign_magnitude_alu.sv
// Pipelined flagged sign-magnitude ALU. One operand transfer is taken every
// cycle (busy stays low). Each result appears on out_item with out_valid high
// for one cycle. The input register loads on the edge that takes a start,
// then a row of 64 cells, each retiring one quotient bit and one multiplier
// bit, and one output register follow. Results leave in start order and
// cannot be stalled.
`include "flagged_sign_magnitude_alu_macros.svh"
module flagged_sign_magnitude_alu (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fsma_pkg::in_item_t  in_item,
  output logic                out_valid,
  output fsma_pkg::out_item_t out_item
);
  import fsma_pkg::*;

  cell_data_t row [Stages+1];
  cell_data_t head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.vld <= 1'b0;
    end else begin
      head_r.vld <= start & !busy;
    end
    head_r.op    <= in_item;
    head_r.rem   <= '0;
    head_r.quo   <= '0;
    head_r.prod  <= '0;
    head_r.mcand <= {{MagW{1'b0}}, in_item.a_magnitude};
  end

  assign busy   = 1'b0;
  assign row[0] = head_r;

  for (genvar i = 0; i < Stages; i++) begin : g_cell
    fsma_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .idx   (IdxW'(Stages-1-i)),
      .d_in  (row[i]),
      .d_out (row[i+1])
    );
  end

  fsma_final u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .d_in      (row[Stages]),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `FSM_ASSERT_NEXT(a_head_vld, clk, rst_n, start, head_r.vld, "accepted start lost")
  `FSM_ASSERT_IMP(a_row_vld, clk, rst_n, row[Stages].vld, $past(head_r.vld, Stages),
    "row valid mismatch")
  `FSM_ASSERT_NEXT(a_out_vld, clk, rst_n, row[Stages].vld, out_valid, "result dropped")
endmodule

>>> rtl/core/fsma_cell.sv
// One step of the shared row: one restoring-divide bit and one
// shift-add multiply bit.
module fsma_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [fsma_pkg::IdxW-1:0] idx,
  input  fsma_pkg::cell_data_t d_in,
  output fsma_pkg::cell_data_t d_out
);
  import fsma_pkg::*;

  cell_data_t        d_r, d_nxt;
  logic [MagW:0]     trial;
  logic [MagW-1:0]   quo_bit_src;

  always_comb begin
    d_nxt = d_in;
    quo_bit_src = d_in.op.a_magnitude >> idx;
    trial = {d_in.rem, quo_bit_src[0]} - {1'b0, d_in.op.b_magnitude};
    if (!trial[MagW]) begin
      d_nxt.rem = trial[MagW-1:0];
      d_nxt.quo = d_in.quo | (MagW'(1) << idx);
    end else begin
      d_nxt.rem = {d_in.rem[MagW-2:0], quo_bit_src[0]};
    end
    if (d_in.op.b_magnitude[MagW-1-idx]) begin
      d_nxt.prod = d_in.prod + (d_in.mcand << (MagW-1-idx));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else begin
      d_r.vld <= d_in.vld;
    end
    d_r.op    <= d_nxt.op;
    d_r.rem   <= d_nxt.rem;
    d_r.quo   <= d_nxt.quo;
    d_r.prod  <= d_nxt.prod;
    d_r.mcand <= d_nxt.mcand;
  end

  assign d_out = d_r;
endmodule

>>> rtl/core/fsma_final.sv
// Flag rules, add/subtract, compare and result selection.
module fsma_final (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fsma_pkg::cell_data_t d_in,
  output logic                 out_valid,
  output fsma_pkg::out_item_t  out_item
);
  import fsma_pkg::*;

  out_item_t         r;
  logic              bpos, same, sa, sb;
  logic [MagW:0]     sum;
  logic [MagW-1:0]   a, b;
  logic              az, bz;
  logic              valid_r;
  out_item_t         item_r;

  always_comb begin
    a = d_in.op.a_magnitude;
    b = d_in.op.b_magnitude;
    az = (a == '0);
    bz = (b == '0);
    sa = d_in.op.a_notnum | d_in.op.a_infinite;
    sb = d_in.op.b_notnum | d_in.op.b_infinite;
    r.r_magnitude = a;
    r.r_positive  = d_in.op.a_positive;
    r.r_infinite  = d_in.op.a_infinite;
    r.r_notnum    = d_in.op.a_notnum;
    r.order       = ORD_LESS;
    bpos = (d_in.op.mode == MODE_SUB) ? !d_in.op.b_positive : d_in.op.b_positive;
    same = (d_in.op.a_positive == bpos);
    sum  = {1'b0, a} + {1'b0, b};
    case (d_in.op.mode)
      MODE_ADD, MODE_SUB: begin
        if (sa || sb) begin
          r.r_notnum = d_in.op.a_notnum | d_in.op.b_notnum |
                       (d_in.op.a_infinite & d_in.op.b_infinite &
                        (d_in.op.a_positive != bpos));
          r.r_infinite = !r.r_notnum & (d_in.op.a_infinite | d_in.op.b_infinite);
          r.r_positive = d_in.op.b_infinite ? bpos : d_in.op.a_positive;
        end else if (same) begin
          if (sum[MagW]) r.r_infinite = 1'b1;
          else r.r_magnitude = sum[MagW-1:0];
        end else if (a < b) begin
          r.r_positive  = !d_in.op.a_positive;
          r.r_magnitude = b - a;
        end else begin
          r.r_magnitude = a - b;
        end
      end
      MODE_MUL: begin
        r.r_positive = (d_in.op.a_positive == d_in.op.b_positive);
        if (sa || sb) begin
          r.r_notnum = d_in.op.a_notnum | d_in.op.b_notnum |
                       (d_in.op.a_infinite & bz) | (az & d_in.op.b_infinite);
          r.r_infinite = !r.r_notnum & (d_in.op.a_infinite | d_in.op.b_infinite);
        end else if (az || bz) begin
          r.r_magnitude = '0;
        end else if (d_in.prod[2*MagW-1:MagW] != '0) begin
          r.r_infinite = 1'b1;
        end else begin
          r.r_magnitude = d_in.prod[MagW-1:0];
        end
      end
      MODE_DIV: begin
        r.r_positive = (d_in.op.a_positive == d_in.op.b_positive);
        if (bz || sa || sb) begin
          r.r_notnum = d_in.op.a_notnum | d_in.op.b_notnum |
                       (d_in.op.a_infinite & d_in.op.b_infinite) | (az & bz);
          r.r_infinite = !r.r_notnum & (d_in.op.a_infinite | (!az & bz));
          if (!r.r_notnum && !r.r_infinite && d_in.op.b_infinite) r.r_magnitude = '0;
        end else begin
          r.r_magnitude = d_in.quo;
        end
      end
      MODE_MOD: begin
        if (bz) begin
          r.r_notnum   = 1'b1;
          r.r_infinite = 1'b0;
        end else begin
          r.r_magnitude = d_in.rem;
        end
      end
      MODE_CMP: begin
        if (d_in.op.a_notnum || d_in.op.b_notnum) r.order = ORD_UNORD;
        else if (d_in.op.a_positive != d_in.op.b_positive)
          r.order = d_in.op.a_positive ? ORD_GREATER : ORD_LESS;
        else if (d_in.op.a_infinite != d_in.op.b_infinite)
          r.order = (d_in.op.a_infinite == d_in.op.a_positive) ? ORD_GREATER : ORD_LESS;
        else if (a == b) r.order = ORD_EQUAL;
        else r.order = ((a > b) == d_in.op.a_positive) ? ORD_GREATER : ORD_LESS;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= d_in.vld;
    end
    item_r <= r;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;
endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import fsma_pkg::*;

  localparam longint unsigned CycleLimit = 400000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  out_item_t expected_q[$];
  int        fail_count;
  int        sent_count;
  int        got_count;
  longint unsigned cycle_count;

  flagged_sign_magnitude_alu i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  typedef struct {
    logic [MagW-1:0] mag;
    logic pos;
    logic inf;
    logic nan;
  } operand_t;

  function automatic operand_t alu_add(operand_t a, operand_t b);
    operand_t r;
    r = a;
    if (a.nan || a.inf || b.nan || b.inf) begin
      r.nan = a.nan | b.nan | (a.inf & b.inf & (a.pos != b.pos));
      r.inf = !r.nan && (a.inf || b.inf);
      r.pos = b.inf ? b.pos : a.pos;
    end else if (a.pos == b.pos) begin
      if ({1'b0, a.mag} + {1'b0, b.mag} > {1'b0, {MagW{1'b1}}}) r.inf = 1'b1;
      else r.mag = a.mag + b.mag;
    end else if (a.mag < b.mag) begin
      r.pos = !a.pos;
      r.mag = b.mag - a.mag;
    end else begin
      r.mag = a.mag - b.mag;
    end
    return r;
  endfunction

  function automatic operand_t alu_mul(operand_t a, operand_t b);
    operand_t r;
    logic [2*MagW-1:0] full;
    r = a;
    r.pos = (a.pos == b.pos);
    full = a.mag * {{MagW{1'b0}}, b.mag};
    if (a.nan || a.inf || b.nan || b.inf) begin
      r.nan = a.nan | b.nan | (a.inf & (b.mag == 0)) | ((a.mag == 0) & b.inf);
      r.inf = !r.nan && (a.inf || b.inf);
    end else if (a.mag == 0 || b.mag == 0) begin
      r.mag = '0;
    end else if (full[2*MagW-1:MagW] != 0) begin
      r.inf = 1'b1;
    end else begin
      r.mag = full[MagW-1:0];
    end
    return r;
  endfunction

  function automatic operand_t alu_div(operand_t a, operand_t b);
    operand_t r;
    r = a;
    r.pos = (a.pos == b.pos);
    if (b.mag == 0 || a.nan || a.inf || b.nan || b.inf) begin
      r.nan = a.nan | b.nan | (a.inf & b.inf) | ((a.mag == 0) & (b.mag == 0));
      r.inf = !r.nan && (a.inf || (a.mag != 0 && b.mag == 0));
      r.mag = (!r.nan && !r.inf && b.inf) ? '0 : a.mag;
    end else begin
      r.mag = a.mag / b.mag;
    end
    return r;
  endfunction

  function automatic order_e alu_compare(operand_t a, operand_t b);
    if (a.nan || b.nan) return ORD_UNORD;
    if (a.pos != b.pos) return a.pos ? ORD_GREATER : ORD_LESS;
    if (a.inf != b.inf) return (a.inf == a.pos) ? ORD_GREATER : ORD_LESS;
    if (a.mag == b.mag) return ORD_EQUAL;
    return ((a.mag > b.mag) == a.pos) ? ORD_GREATER : ORD_LESS;
  endfunction

  function automatic out_item_t alu_result(in_item_t it);
    operand_t a, b, r;
    out_item_t o;
    order_e ord;
    a = '{it.a_magnitude, it.a_positive, it.a_infinite, it.a_notnum};
    b = '{it.b_magnitude, it.b_positive, it.b_infinite, it.b_notnum};
    r = a;
    ord = ORD_LESS;
    case (it.mode)
      MODE_ADD: r = alu_add(a, b);
      MODE_SUB: begin
        b.pos = !b.pos;
        r = alu_add(a, b);
      end
      MODE_MUL: r = alu_mul(a, b);
      MODE_DIV: r = alu_div(a, b);
      MODE_MOD: begin
        if (b.mag == 0) begin
          r.nan = 1'b1;
          r.inf = 1'b0;
        end else begin
          r.mag = a.mag % b.mag;
        end
      end
      MODE_CMP: ord = alu_compare(a, b);
      default: ;
    endcase
    o.r_magnitude = r.mag;
    o.r_positive  = r.pos;
    o.r_infinite  = r.inf;
    o.r_notnum    = r.nan;
    o.order       = ord;
    return o;
  endfunction

  // Check each result transfer against the oldest prediction.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) begin
      out_item_t exp_r;
      got_count <= got_count + 1;
      if (expected_q.size() == 0) begin
        $error("result with no prediction pending");
        fail_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_item.r_magnitude !== exp_r.r_magnitude) begin
          $error("r_magnitude: expected %h, got %h", exp_r.r_magnitude, out_item.r_magnitude);
          fail_count++;
        end
        if (out_item.r_positive !== exp_r.r_positive) begin
          $error("r_positive: expected %b, got %b", exp_r.r_positive, out_item.r_positive);
          fail_count++;
        end
        if (out_item.r_infinite !== exp_r.r_infinite) begin
          $error("r_infinite: expected %b, got %b", exp_r.r_infinite, out_item.r_infinite);
          fail_count++;
        end
        if (out_item.r_notnum !== exp_r.r_notnum) begin
          $error("r_notnum: expected %b, got %b", exp_r.r_notnum, out_item.r_notnum);
          fail_count++;
        end
        if (out_item.order !== exp_r.order) begin
          $error("order: expected %0d, got %0d", exp_r.order, out_item.order);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Drop start for a random number of cycles; skip when the gap is empty.
  task automatic wait_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drive one item and hold start until the transfer happens.
  task automatic send_item(in_item_t it, bit gaps);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(alu_result(it));
    sent_count++;
    if (gaps && $urandom_range(0, 2) == 0) begin
      wait_gap();
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [MagW-1:0] rand_mag();
    logic [MagW-1:0] m;
    m = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: m = '0;
      1: m = '1;
      2: m = m >> $urandom_range(1, MagW - 1);
      3: m = m & 64'hff;
      4: m = m >> (MagW / 2);
      default: ;
    endcase
    return m;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.mode        = 3'($urandom_range(0, 7));
    it.a_magnitude = rand_mag();
    it.b_magnitude = ($urandom_range(0, 5) == 0) ? it.a_magnitude : rand_mag();
    it.a_positive  = 1'($urandom_range(0, 1));
    it.b_positive  = 1'($urandom_range(0, 1));
    it.a_infinite  = ($urandom_range(0, 5) == 0);
    it.b_infinite  = ($urandom_range(0, 5) == 0);
    it.a_notnum    = ($urandom_range(0, 7) == 0);
    it.b_notnum    = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  function automatic in_item_t mk(logic [2:0] m, logic [MagW-1:0] am, logic [2:0] af,
                                  logic [MagW-1:0] bm, logic [2:0] bf);
    return '{m, am, af[2], af[1], af[0], bm, bf[2], bf[1], bf[0]};
  endfunction

  // Flags are {positive, infinite, notnum}.
  task automatic test_special_cases();
    send_item(mk(MODE_ADD, '1, 3'b100, 64'd1, 3'b100), 0);
    send_item(mk(MODE_ADD, 64'd5, 3'b110, 64'd5, 3'b010), 0);
    send_item(mk(MODE_ADD, 64'd5, 3'b100, 64'd9, 3'b010), 0);
    send_item(mk(MODE_ADD, 64'd3, 3'b000, 64'd9, 3'b100), 0);
    send_item(mk(MODE_SUB, 64'd3, 3'b100, 64'd9, 3'b100), 0);
    send_item(mk(MODE_SUB, 64'd3, 3'b110, 64'd9, 3'b110), 0);
    send_item(mk(MODE_MUL, '1, 3'b100, 64'd2, 3'b000), 0);
    send_item(mk(MODE_MUL, 64'd0, 3'b100, 64'd7, 3'b010), 0);
    send_item(mk(MODE_MUL, 64'd7, 3'b110, 64'd0, 3'b100), 0);
    send_item(mk(MODE_MUL, 64'd0, 3'b100, '1, 3'b000), 0);
    send_item(mk(MODE_MUL, 64'hffffffff, 3'b000, 64'hffffffff, 3'b100), 0);
    send_item(mk(MODE_DIV, 64'd9, 3'b100, 64'd0, 3'b100), 0);
    send_item(mk(MODE_DIV, 64'd0, 3'b100, 64'd0, 3'b000), 0);
    send_item(mk(MODE_DIV, 64'd9, 3'b100, 64'd4, 3'b110), 0);
    send_item(mk(MODE_DIV, 64'd9, 3'b110, 64'd4, 3'b010), 0);
    send_item(mk(MODE_DIV, '1, 3'b100, 64'd3, 3'b000), 0);
    send_item(mk(MODE_MOD, '1, 3'b011, 64'd0, 3'b100), 0);
    send_item(mk(MODE_MOD, '1, 3'b110, 64'd10, 3'b001), 0);
    send_item(mk(MODE_CMP, 64'd4, 3'b001, 64'd4, 3'b100), 0);
    send_item(mk(MODE_CMP, 64'd4, 3'b000, 64'd4, 3'b000), 0);
    send_item(mk(MODE_CMP, 64'd4, 3'b000, 64'd9, 3'b000), 0);
    send_item(mk(MODE_CMP, 64'd4, 3'b010, 64'd9, 3'b000), 0);
    send_item(mk(MODE_CMP, 64'd4, 3'b100, 64'd9, 3'b000), 0);
    send_item(mk(3'd6, '1, 3'b111, '1, 3'b111), 0);
    send_item(mk(3'd7, 64'd0, 3'b000, 64'd0, 3'b000), 0);
  endtask

  task automatic test_random_stream(int count);
    for (int i = 0; i < count; i++) begin
      send_item(rand_item(), ($urandom_range(0, 3) != 0));
      // Hold off once midway until the pipeline is empty.
      if (i == count / 2) drain();
    end
  endtask

  task automatic test_back_to_back(int count);
    for (int i = 0; i < count; i++) send_item(rand_item(), 0);
  endtask

  initial begin
    fail_count  = 0;
    sent_count  = 0;
    got_count   = 0;
    cycle_count = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_random_stream(425);
    test_back_to_back(100);
    drain();
    repeat (Lat + 10) @(posedge clk);
    $display("Sent %0d operand pairs, checked %0d results: all modes, special values,",
             sent_count, got_count);
    $display("overflow, zero divisors, undefined modes, random gaps and one full drain.");
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
